// ===== src/npsl_pkg.sv =====
// Shared types, codes and helpers for the nearest preceding symbol lookup block.
`default_nettype none

package npsl_pkg;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_W       = 17;
  localparam int INDEX_W     = 10;
  localparam int VALUE_W     = 16;
  localparam int OVL_W       = 8;
  localparam int CLS_W       = 2;
  localparam int ENTRY_W     = CLS_W + OVL_W + VALUE_W;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  localparam logic [CLS_W-1:0] CLS_NONE = 2'd0;
  localparam logic [CLS_W-1:0] CLS_TEXT = 2'd1;
  localparam logic [CLS_W-1:0] CLS_DATA = 2'd2;

  localparam logic REG_TEXT_BASE  = 1'b0;
  localparam logic REG_MAX_OFFSET = 1'b1;

  localparam logic [CFG_W-1:0] MAX_OFFSET_RST = 17'd2048;
  localparam logic [CFG_W-1:0] DIFF_INIT      = 17'h1FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } npsl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } npsl_sts_t;

  function automatic logic [CLS_W-1:0] classify(input logic [7:0] flags);
    logic [CLS_W-1:0] cls;
    if (flags >= 8'o41 || (flags >= 8'd1 && flags <= 8'd4)) begin
      cls = (flags[2:0] == 3'o2) ? CLS_TEXT : CLS_DATA;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== src/nearest_preceding_symbol_lookup.sv =====
// Top level of the nearest preceding symbol lookup block.
//
//  channel | dir | payload
//  --------+-----+---------------------------------------------------------------
//  in_     | in  | tuser: req_type; tdata: sym_value, sym_overlay, sym_flags,
//          |     |        address, want_text, current_overlay
//  out_    | out | tuser: status; tdata: entry_index, offset, entry_overlay
//  cfg_    | in  | index 0 text_base, index 1 max_offset
//
// Clear and append go from accept straight to the result state. A lookup first scans
// the stored entries, at most MAX_SYMBOLS of them: the table RAM is read one entry per
// cycle through its single read port. One request is in flight at a time; a new
// request is taken while the previous result waits in the output register. Reset
// empties the table at once and loads the register defaults. A stalled output holds
// the sequencer in its result state.
`default_nettype none

module nearest_preceding_symbol_lookup
  import npsl_pkg::*;
#(
  parameter int MAX_SYMBOLS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [15:0] sym_value, [23:16] sym_overlay, [31:24] sym_flags, [47:32] address,
  // [48] want_text, [56:49] current_overlay
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [9:0] entry_index, [25:10] offset, [33:26] entry_overlay
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // [1:0] status
  output logic [1:0]                  out_tuser
);

  npsl_cmd_t cmd;
  npsl_sts_t sts;

  npsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  npsl_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== src/npsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module npsl_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/npsl_ctrl.sv =====
// Request sequencer: accept, scan and result hand-off.
`default_nettype none

module npsl_ctrl
  import npsl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_tuser,
  output logic            in_tready,
  input  wire npsl_sts_t  sts,
  output npsl_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser == REQ_LOOKUP) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: cmd.issue = !sts.scan_end;
      ST_DONE: cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_issue_before_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !sts.scan_end)
    else $error("read issued past the table end");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !sts.out_free) |=> state_r == ST_DONE)
    else $error("result dropped while output busy");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== src/npsl_dp.sv =====
// Datapath: symbol table, scan compare, best-match tracking, result register.
`default_nettype none

module npsl_dp
  import npsl_pkg::*;
#(
  parameter int MAX_SYMBOLS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [1:0]                  out_tuser,
  input  wire npsl_cmd_t              cmd,
  output npsl_sts_t                   sts
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SYMBOLS);

  // Request fields
  logic [VALUE_W-1:0] in_value;
  logic [OVL_W-1:0]   in_ovl;
  logic [7:0]         in_flags;
  logic [VALUE_W-1:0] in_addr;
  logic               in_want_text;
  logic [OVL_W-1:0]   in_cur_ovl;

  assign in_value     = in_tdata[15:0];
  assign in_ovl       = in_tdata[23:16];
  assign in_flags     = in_tdata[31:24];
  assign in_addr      = in_tdata[47:32];
  assign in_want_text = in_tdata[48];
  assign in_cur_ovl   = in_tdata[56:49];

  logic [CFG_W-1:0] text_base_r, max_offset_r;
  logic [CNT_W-1:0] count_r, scan_idx_r;
  logic             rd_pend_r;
  logic             found_r;
  logic             out_valid_r;

  logic [1:0]         req_r;
  logic               drop_r;
  logic [VALUE_W-1:0] addr_r;
  logic [CLS_W-1:0]   want_cls_r;
  logic [OVL_W-1:0]   ovl_filter_r;
  logic [CFG_W-1:0]   best_diff_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [OVL_W-1:0]   best_ovl_r;
  logic [IDX_W-1:0]   rd_idx_r;

  logic [1:0]         out_status_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [VALUE_W-1:0] out_offset_r;
  logic [OVL_W-1:0]   out_ovl_r;

  logic               full;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [CLS_W-1:0]   rd_cls;
  logic [OVL_W-1:0]   rd_ovl;
  logic [VALUE_W-1:0] rd_value;
  logic [VALUE_W-1:0] diff;
  logic               better;
  logic               use_filter;
  logic               hit;

  function automatic logic [VALUE_W-1:0] in_addr_diff(input logic [VALUE_W-1:0] a,
                                                     input logic [VALUE_W-1:0] v);
    return a - v;
  endfunction

  assign full   = (count_r == CNT_MAX);
  assign ram_we = cmd.load && in_tuser == REQ_APPEND && !full;

  npsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({classify(in_flags), in_ovl, in_value}),
    .raddr (scan_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_cls   = ram_rdata[ENTRY_W-1 -: CLS_W];
  assign rd_ovl   = ram_rdata[VALUE_W +: OVL_W];
  assign rd_value = ram_rdata[VALUE_W-1:0];
  assign diff     = in_addr_diff(addr_r, rd_value);

  assign better = rd_pend_r && rd_cls == want_cls_r
                  && (ovl_filter_r == '0 || rd_ovl == ovl_filter_r)
                  && addr_r >= rd_value && {1'b0, diff} < best_diff_r;

  assign use_filter = text_base_r != '0 && in_want_text && {1'b0, in_addr} > text_base_r;
  assign hit        = found_r && best_diff_r < max_offset_r;

  assign sts.scan_end = (scan_idx_r == count_r);
  assign sts.out_free = !out_valid_r || out_tready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r  <= '0;
      max_offset_r <= MAX_OFFSET_RST;
      count_r      <= '0;
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TEXT_BASE:  text_base_r  <= cfg_wdata;
          REG_MAX_OFFSET: max_offset_r <= cfg_wdata;
          default:        text_base_r  <= text_base_r;
        endcase
      end
      if (cmd.load && in_tuser == REQ_CLEAR) begin
        count_r <= '0;
      end else if (ram_we) begin
        count_r <= count_r + CNT_W'(1);
      end
      rd_pend_r <= cmd.issue;
      if (cmd.load) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.issue) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
        if (better) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r[IDX_W-1:0];
    if (cmd.load) begin
      req_r        <= in_tuser;
      drop_r       <= full;
      addr_r       <= in_addr;
      want_cls_r   <= in_want_text ? CLS_TEXT : CLS_DATA;
      ovl_filter_r <= use_filter ? in_cur_ovl : '0;
      best_diff_r  <= DIFF_INIT;
      best_idx_r   <= '0;
      best_ovl_r   <= '0;
    end else if (better) begin
      best_diff_r <= {1'b0, diff};
      best_idx_r  <= rd_idx_r;
      best_ovl_r  <= rd_ovl;
    end
    if (cmd.finish) begin
      out_status_r <= STS_OK;
      out_index_r  <= '0;
      out_offset_r <= '0;
      out_ovl_r    <= '0;
      case (req_r)
        REQ_APPEND: begin
          if (drop_r) begin
            out_status_r <= STS_FULL;
          end
        end
        REQ_LOOKUP: begin
          if (hit) begin
            out_index_r  <= INDEX_W'(best_idx_r);
            out_offset_r <= best_diff_r[VALUE_W-1:0];
            out_ovl_r    <= best_ovl_r;
          end else begin
            out_status_r <= STS_NOT_FOUND;
          end
        end
        default: out_status_r <= STS_OK;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - INDEX_W - VALUE_W - OVL_W){1'b0}},
                       out_ovl_r, out_offset_r, out_index_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("entry count above table size");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !full)
    else $error("append written into a full table");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STS_OK) |-> (out_index_r == '0 && out_offset_r == '0
                                                 && out_ovl_r == '0))
    else $error("nonzero payload on a miss or drop");

endmodule

`default_nettype wire
